[hdl/qpv_pkg.sv]
`default_nettype none

package qpv_pkg;

    // position, velocity and elapsed time are all 32-bit words
    localparam int CNT_W = 32;

    // milliseconds per second, and the bits it needs
    localparam int MS_W = 10;
    localparam logic [MS_W-1:0] MS_PER_SEC = 10'd1000;

    localparam int RATE_FRAC_BITS_DEF = 8;

    localparam int OPCODE_W = 3;

    localparam logic [CNT_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [CNT_W-1:0] VEL_MIN = 32'h8000_0000;

    typedef enum logic [OPCODE_W-1:0] {
        OP_EDGE_A = 3'd0,
        OP_EDGE_B = 3'd1,
        OP_TICK   = 3'd2,
        OP_QUERY  = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

[hdl/qpv_div.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle
module qpv_div import qpv_pkg::*; #(
    parameter int DW = CNT_W + MS_W + RATE_FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DW-1:0]    i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic [DW-1:0]         o_quotient,
    output t_div_status           o_status
);

    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST = CW'(DW - 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [CNT_W-1:0] r_rem;
    logic [DW-1:0]    r_quo;
    logic [CNT_W-1:0] r_dvs;

    logic [CNT_W:0]   w_trial;
    logic [CNT_W:0]   w_diff;
    logic             w_fit;

    // shift the next dividend bit into the partial remainder
    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_fit   = (w_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_quo <= {r_quo[DW-2:0], w_fit};
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_busy && (r_cnt == LAST);

endmodule

`default_nettype wire

[hdl/quadrature_position_velocity.sv]
// x4 quadrature position counter with a velocity estimate
// input stream: one request per event; s_axis_tuser carries the opcode (edge on a,
// edge on b, millisecond tick, velocity query, clear), s_axis_tdata the pin levels
// output stream: one request per input, carrying position and velocity after it
// edges, ticks, clears and queries with zero elapsed time: result is in the output
// register in the cycle after acceptance, and a new request can be taken every cycle
// while the receiver keeps up
// velocity query with elapsed time above zero: ST_MUL multiplies the position
// change by 1000 and starts the restoring divider, ST_DIV waits on it (one
// quotient bit a cycle), then ST_DONE saturates the result at Q23.8
// no new request is taken while the divider runs
// velocity is signed with RATE_FRAC_BITS fraction bits, saturating at 32 bits
// reset clears position, last query position, velocity and elapsed time
// if the receiver stalls the result stays in the output register and the input
// side is held off until it has been taken
`default_nettype none

module quadrature_position_velocity import qpv_pkg::*; #(
    parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,  // a_level, b_level, zero pad
    input  wire logic [OPCODE_W-1:0] s_axis_tuser,  // opcode
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [2*CNT_W-1:0]       m_axis_tdata   // position, velocity
);

    localparam int PW = CNT_W + MS_W;
    localparam int DW = PW + RATE_FRAC_BITS;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_last, n_last;
    logic [CNT_W-1:0] r_rate, n_rate;
    logic [CNT_W-1:0] r_elapsed, n_elapsed;
    logic             r_neg, n_neg;
    logic [CNT_W-1:0] r_mag, n_mag;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_pos;
    logic [CNT_W-1:0] r_out_vel;

    logic             w_accept;
    logic             w_out_free;
    logic             w_same;
    logic             w_long_query;
    logic             w_load_out;
    logic             w_div_start;
    logic [CNT_W-1:0] w_diff;
    logic [PW-1:0]    w_prod;
    logic [DW-1:0]    w_dividend;
    logic [DW-1:0]    w_quo;
    logic             w_over;
    logic [CNT_W-1:0] w_sat;
    t_div_status      w_div_st;

    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_same       = (s_axis_tdata[0] == s_axis_tdata[1]);
    assign w_long_query = (t_op'(s_axis_tuser) == OP_QUERY) && (r_elapsed != '0);
    assign w_diff       = r_count - r_last;

    // change times 1000, scaled up by the fraction bits
    assign w_prod     = {{MS_W{1'b0}}, r_mag} * {{CNT_W{1'b0}}, MS_PER_SEC};
    assign w_dividend = DW'(w_prod) << RATE_FRAC_BITS;

    qpv_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_elapsed),
        .o_quotient (w_quo),
        .o_status   (w_div_st)
    );

    // saturate the magnitude quotient and put the sign back
    always_comb begin
        w_over = |w_quo[DW-1:CNT_W-1];
        if (r_neg) begin
            w_sat = w_over ? VEL_MIN : (~w_quo[CNT_W-1:0] + 1'b1);
        end else begin
            w_sat = w_over ? VEL_MAX : w_quo[CNT_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_long_query) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_st.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_load_out    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = w_out_free;
                w_load_out    = w_accept && !w_long_query;
            end
            ST_MUL:  w_div_start = 1'b1;
            ST_DIV:  w_div_start = 1'b0;
            ST_DONE: w_load_out  = w_out_free;
            default: w_load_out  = 1'b0;
        endcase
    end

    // tracking state updates
    always_comb begin
        n_count   = r_count;
        n_last    = r_last;
        n_rate    = r_rate;
        n_elapsed = r_elapsed;
        n_neg     = r_neg;
        n_mag     = r_mag;
        if (w_accept) begin
            case (t_op'(s_axis_tuser))
                OP_EDGE_A: n_count = w_same ? r_count + 1'b1 : r_count - 1'b1;
                OP_EDGE_B: n_count = w_same ? r_count - 1'b1 : r_count + 1'b1;
                OP_TICK:   n_elapsed = r_elapsed + 1'b1;
                OP_QUERY: begin
                    // magnitude of the most negative change is still 2^31 unsigned
                    n_neg = w_diff[CNT_W-1];
                    n_mag = w_diff[CNT_W-1] ? (~w_diff + 1'b1) : w_diff;
                end
                OP_CLEAR: begin
                    n_count = '0;
                    n_last  = '0;
                    n_rate  = '0;
                end
                default: n_count = r_count;
            endcase
        end else if (r_state == ST_DONE && w_out_free) begin
            n_rate    = w_sat;
            n_last    = r_count;
            n_elapsed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_last      <= '0;
            r_rate      <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_last    <= n_last;
            r_rate    <= n_rate;
            r_elapsed <= n_elapsed;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_mag <= n_mag;
        if (w_load_out) begin
            r_out_pos <= n_count;
            r_out_vel <= n_rate;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_vel, r_out_pos};

    // a query with time on the clock must start the divide sequence
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_long_query) |=> (r_state == ST_MUL))
        else $error("query did not start the divide");

    // the divider runs exactly while the sequencer waits on it
    a_div_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_st.busy == (r_state == ST_DIV)))
        else $error("divider out of step with sequencer");

    // finishing a query rebases the position and restarts the time
    a_query_rebase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> (r_elapsed == '0 && r_last == r_count))
        else $error("query did not rebase");

    // a short request always leaves a result in the output register
    a_short_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_long_query) |=> m_axis_tvalid)
        else $error("missing result after short request");

endmodule

`default_nettype wire
